// ----- hw/rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Depth, field widths, operation and status codes, and the cell commands.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;
  localparam int unsigned OccW    = $clog2(DEPTH + 1);

  localparam logic signed [DataW-1:0] EmptyData = -32'sd1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_REVERSE    = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_SHIFT_IN  = 3'd1,  // take the left neighbor, cell 0 takes the new value
    CELL_SHIFT_OUT = 3'd2,  // take the right neighbor
    CELL_FILL_TAIL = 3'd3,  // first empty cell takes the new value
    CELL_DROP_TAIL = 3'd4   // last full cell empties
  } cell_cmd_e;

endpackage

// ----- hw/rtl/dq_cell.sv -----
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue row
// Holds one element and its valid bit, and moves data to or from its
// neighbors under the broadcast command.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dq_pkg::cell_cmd_e                 cmd_i,
  input  logic signed [dq_pkg::DataW-1:0]   prev_data_i,
  input  logic                              prev_valid_i,
  input  logic signed [dq_pkg::DataW-1:0]   next_data_i,
  input  logic                              next_valid_i,
  output logic signed [dq_pkg::DataW-1:0]   data_o,
  output logic                              valid_o,
  output logic signed [dq_pkg::DataW-1:0]   tail_o
);
  import dq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    valid_q, valid_d;
  logic                    is_tail;

  assign is_tail = valid_q & ~next_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (cmd_i)
      CELL_SHIFT_IN: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      CELL_SHIFT_OUT: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      CELL_FILL_TAIL: begin
        if (!valid_q && prev_valid_i) begin
          data_d  = prev_data_i;
          valid_d = 1'b1;
        end
      end
      CELL_DROP_TAIL: begin
        if (is_tail) valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tail_o  = is_tail ? data_q : '0;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue: fixed-depth deque of signed 32-bit values
// A row of cells; cell 0 is the physical front, the last valid cell the back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i and value_i. Output
//   channel (out_valid_o / out_stall_i) carries status_o, data_o, count_o.
//   Every accepted beat yields exactly one result beat.
//   The result is registered: it sits in the output register on the
//   clock after the input beat is taken. One beat per cycle is sustained
//   while out_stall_i is low; every cell updates in parallel from its
//   neighbors. Pushes at the physical front shift the whole row right, pops
//   there shift it left; the back end fills or empties the cell at the edge
//   of the valid run. Peek back is an OR over the one-hot tail of the row.
//   Reverse toggles a direction flag that swaps the logical ends.
//   Reset empties the queue and clears the direction flag; no sweep needed.
//   While the output holds an unaccepted result and out_stall_i is high,
//   in_stall_o is raised and the result holds.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dq_pkg::OpW-1:0]              op_i,
  input  logic signed [dq_pkg::DataW-1:0]     value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dq_pkg::StatusW-1:0]          status_o,
  output logic signed [dq_pkg::DataW-1:0]     data_o,
  output logic [dq_pkg::CountW-1:0]           count_o
);
  import dq_pkg::*;

  logic signed [DataW-1:0] cell_data  [DEPTH];
  logic                    cell_valid [DEPTH];
  logic signed [DataW-1:0] cell_tail  [DEPTH];

  cell_cmd_e               cmd;
  logic                    accept;
  logic [OccW-1:0]         occ_q, occ_d;
  logic                    rev_q, rev_d;
  logic                    at_front;
  logic                    is_empty, is_full;
  logic signed [DataW-1:0] back_data;
  status_e                 status_d;
  logic signed [DataW-1:0] res_data_d;

  logic                    out_valid_q;
  logic [StatusW-1:0]      status_q;
  logic signed [DataW-1:0] data_q;
  logic [CountW-1:0]       count_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] prev_data, next_data;
    logic                    prev_valid, next_valid;

    if (i == 0) begin : g_head
      assign prev_data  = value_i;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    // Cells past the head take the new value only through FILL_TAIL,
    // so route it in where the cell is the first empty one.
    logic signed [DataW-1:0] fill_data;
    assign fill_data = (cmd == CELL_FILL_TAIL) ? value_i : prev_data;

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_data_i  (fill_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .tail_o       (cell_tail[i])
    );
  end

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tail[i];
    end
  end

  assign is_empty = (occ_q == '0);
  assign is_full  = (occ_q == OccW'(DEPTH));

  always_comb begin
    cmd        = CELL_HOLD;
    occ_d      = occ_q;
    rev_d      = rev_q;
    status_d   = ST_OK;
    res_data_d = '0;
    at_front   = 1'b0;
    case (op_i)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        at_front = (op_i == OP_PUSH_FRONT) ^ rev_q;
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          cmd   = at_front ? CELL_SHIFT_IN : CELL_FILL_TAIL;
          occ_d = occ_q + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        at_front = (op_i == OP_POP_FRONT) ^ rev_q;
        if (is_empty) begin
          status_d   = ST_EMPTY;
          res_data_d = EmptyData;
        end else begin
          cmd   = at_front ? CELL_SHIFT_OUT : CELL_DROP_TAIL;
          occ_d = occ_q - 1'b1;
        end
      end
      OP_PEEK_FRONT, OP_PEEK_BACK: begin
        at_front = (op_i == OP_PEEK_FRONT) ^ rev_q;
        if (is_empty) begin
          status_d   = ST_EMPTY;
          res_data_d = EmptyData;
        end else begin
          res_data_d = at_front ? cell_data[0] : back_data;
        end
      end
      OP_REVERSE: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rev_d = ~rev_q;
        end
      end
      default: begin
      end
    endcase
    // drop every state change unless a beat is taken
    if (!accept) begin
      cmd   = CELL_HOLD;
      occ_d = occ_q;
      rev_d = rev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      rev_q       <= rev_d;
      out_valid_q <= accept | in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= res_data_d;
      count_q  <= CountW'(occ_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign count_o     = count_q;

endmodule
